### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the LRU/TTL cache table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset
`define LCT_ASSERT_IMPLY(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("cache table assertion failed");

// Next-cycle implication, masked during reset
`define LCT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("cache table assertion failed");

// Next-cycle implication that also holds across reset
`define LCT_ASSERT_NEXT_NORST(lbl, clk, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("cache table assertion failed");

`endif

### rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Types, codes and constants shared by the LRU cache table with TTL expiry.
// ----------------------------------------------------------------------------
package lct_pkg;

  // Fixed field widths
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int CAP_W       = 7;
  localparam int TTL_W       = 31;
  localparam int STAMP_W     = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;

  // Parameter defaults
  localparam int DEF_ENTRIES    = 64;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 32;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [TTL_W-1:0] TTL_RESET = 31'd3600;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TTL      = 2'd1;

  // Request operations
  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2
  } lct_op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    RES_MISS     = 3'd0,
    RES_HIT      = 3'd1,
    RES_EXPIRED  = 3'd2,
    RES_INSERTED = 3'd3,
    RES_REPLACED = 3'd4,
    RES_EVICTED  = 3'd5,
    RES_TICK     = 3'd6
  } lct_status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_TAIL,
    S_DECIDE,
    S_SWEEP,
    S_SWEEP_TAIL,
    S_FINISH
  } lct_state_t;

  // Recency update applied by the sweep
  typedef enum logic [1:0] {
    MODE_TOUCH,
    MODE_REMOVE,
    MODE_ADD
  } lct_mode_t;

  // Write strobes from sequencer to entry store
  typedef struct packed {
    logic kvs_we;
    logic rank_we;
    logic valid_clr;
    logic valid_set;
  } lct_mem_ctl_t;

  // Result handed from sequencer to output register
  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
  } lct_res_t;

endpackage

### rtl/lct_store.sv
// ----------------------------------------------------------------------------
// lct_store
// Entry store: key, value, stamp and recency memories with registered reads,
// plus per-entry valid flops cleared at reset.
// ----------------------------------------------------------------------------
module lct_store import lct_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int IDX_W     = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lct_mem_ctl_t          ctl,
  input  logic [IDX_W-1:0]      raddr,
  input  logic [IDX_W-1:0]      kvs_addr,
  input  logic [KEY_BITS-1:0]   wkey,
  input  logic [VALUE_BITS-1:0] wvalue,
  input  logic [STAMP_W-1:0]    wstamp,
  input  logic [IDX_W-1:0]      rank_addr,
  input  logic [IDX_W-1:0]      wrank,
  input  logic [IDX_W-1:0]      clr_idx,
  input  logic [IDX_W-1:0]      set_idx,
  output logic                  rd_valid,
  output logic [KEY_BITS-1:0]   rd_key,
  output logic [VALUE_BITS-1:0] rd_value,
  output logic [STAMP_W-1:0]    rd_stamp,
  output logic [IDX_W-1:0]      rd_rank
);

  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem [ENTRIES];
  logic [IDX_W-1:0]      rank_mem  [ENTRIES];
  logic [ENTRIES-1:0]    valid;

  // Write key, value and stamp of one slot
  always_ff @(posedge clk) begin
    if (ctl.kvs_we) begin
      key_mem[kvs_addr]   <= wkey;
      value_mem[kvs_addr] <= wvalue;
      stamp_mem[kvs_addr] <= wstamp;
    end
  end

  // Write back one recency rank
  always_ff @(posedge clk) begin
    if (ctl.rank_we) begin
      rank_mem[rank_addr] <= wrank;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    rd_key   <= key_mem[raddr];
    rd_value <= value_mem[raddr];
    rd_stamp <= stamp_mem[raddr];
    rd_rank  <= rank_mem[raddr];
    rd_valid <= valid[raddr];
  end

  // Valid flags: set wins over clear on the same slot
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctl.valid_clr) begin
        valid[clr_idx] <= 1'b0;
      end
      if (ctl.valid_set) begin
        valid[set_idx] <= 1'b1;
      end
    end
  end

endmodule

### rtl/lct_seq.sv
// ----------------------------------------------------------------------------
// lct_seq
// Sequencer and shared compare/update unit: for lookups and inserts, walks
// the entry store once to match the key and find free and least recent slots,
// decides, then walks it again to rewrite recency ranks unless a lookup missed.
// ----------------------------------------------------------------------------
module lct_seq import lct_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int IDX_W     = $clog2(ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  busy,
  input  logic [OP_W-1:0]       op,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [CAP_W-1:0]      capacity,
  input  logic [TTL_W-1:0]      ttl,
  output lct_mem_ctl_t          mem_ctl,
  output logic [IDX_W-1:0]      raddr,
  output logic [IDX_W-1:0]      kvs_addr,
  output logic [KEY_BITS-1:0]   wkey,
  output logic [VALUE_BITS-1:0] wvalue,
  output logic [STAMP_W-1:0]    wstamp,
  output logic [IDX_W-1:0]      rank_addr,
  output logic [IDX_W-1:0]      wrank,
  output logic [IDX_W-1:0]      clr_idx,
  output logic [IDX_W-1:0]      set_idx,
  input  logic                  rd_valid,
  input  logic [KEY_BITS-1:0]   rd_key,
  input  logic [VALUE_BITS-1:0] rd_value,
  input  logic [STAMP_W-1:0]    rd_stamp,
  input  logic [IDX_W-1:0]      rd_rank,
  output lct_res_t              res,
  output logic [VALUE_BITS-1:0] res_handle,
  input  logic                  res_ready
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  lct_state_t state, state_next;

  logic                  accept;
  logic [IDX_W-1:0]      idx;
  logic                  idx_last;
  logic                  issue;
  logic                  rd_pend;
  logic [IDX_W-1:0]      rd_idx;
  logic                  scan_proc;
  logic                  sweep_proc;

  // Held request
  logic [OP_W-1:0]       op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // Scan results
  logic                  hit_found;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      hit_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [STAMP_W-1:0]    hit_stamp;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;
  logic                  lr_found;
  logic [IDX_W-1:0]      lr_idx;
  logic [IDX_W-1:0]      lr_rank;
  logic [VALUE_BITS-1:0] lr_value;

  // Sweep set-up
  lct_mode_t             mode;
  logic [IDX_W-1:0]      ref_rank;
  logic [IDX_W-1:0]      target_idx;
  logic                  evict;

  // Table state
  logic [OCC_W-1:0]      occ;
  logic [STAMP_W-1:0]    tick_count;
  logic [STATUS_W-1:0]   status_q;
  logic [VALUE_BITS-1:0] handle_q;

  // Decision outputs
  logic [STAMP_W-1:0]    age;
  logic                  expired;
  logic [CW-1:0]         cap_ext;
  logic [CW-1:0]         cap_eff;
  logic                  need_evict;
  logic                  do_evict;
  logic [STATUS_W-1:0]   dec_status;
  logic [VALUE_BITS-1:0] dec_handle;
  lct_mode_t             dec_mode;
  logic [IDX_W-1:0]      dec_ref;
  logic [IDX_W-1:0]      dec_target;
  logic                  dec_kvs_we;
  logic                  dec_clr;
  logic [IDX_W-1:0]      dec_clr_idx;
  logic                  dec_set;
  logic [OCC_W-1:0]      dec_occ;
  logic                  dec_sweep;

  assign accept     = in_valid && (state == S_IDLE);
  assign busy       = (state != S_IDLE);
  assign idx_last   = (idx == IDX_W'(ENTRIES - 1));
  assign issue      = (state == S_SCAN) || (state == S_SWEEP);
  assign scan_proc  = rd_pend && ((state == S_SCAN) || (state == S_SCAN_TAIL));
  assign sweep_proc = rd_pend && ((state == S_SWEEP) || (state == S_SWEEP_TAIL));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_TICK) begin
            state_next = S_FINISH;
          end else if ((op == OP_LOOKUP) || (op == OP_INSERT)) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_last) begin
          state_next = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: state_next = S_DECIDE;
      S_DECIDE: begin
        state_next = dec_sweep ? S_SWEEP : S_FINISH;
      end
      S_SWEEP: begin
        if (idx_last) begin
          state_next = S_SWEEP_TAIL;
        end
      end
      S_SWEEP_TAIL: state_next = S_FINISH;
      S_FINISH: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decide the outcome from the scan results
  always_comb begin
    age        = tick_count - hit_stamp;
    expired    = age > STAMP_W'(ttl);
    cap_ext    = CW'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
    need_evict  = (CW'(occ) >= cap_eff) || !free_found;
    do_evict    = need_evict && lr_found;
    dec_status  = RES_MISS;
    dec_handle  = '0;
    dec_mode    = MODE_TOUCH;
    dec_ref     = hit_rank;
    dec_target  = hit_idx;
    dec_kvs_we  = 1'b0;
    dec_clr     = 1'b0;
    dec_clr_idx = hit_idx;
    dec_set     = 1'b0;
    dec_occ     = occ;
    dec_sweep   = 1'b0;
    if (op_q == OP_LOOKUP) begin
      if (hit_found) begin
        dec_handle = hit_value;
        dec_sweep  = 1'b1;
        if (expired) begin
          dec_status = RES_EXPIRED;
          dec_mode   = MODE_REMOVE;
          dec_clr    = 1'b1;
          dec_occ    = occ - OCC_W'(1);
        end else begin
          dec_status = RES_HIT;
        end
      end
    end else if (hit_found) begin
      // Replace in place
      dec_status = RES_REPLACED;
      dec_handle = hit_value;
      dec_kvs_we = 1'b1;
      dec_sweep  = 1'b1;
    end else begin
      // Add, evicting the least recent entry first when needed
      dec_status = do_evict ? RES_EVICTED : RES_INSERTED;
      dec_handle = do_evict ? lr_value : '0;
      dec_mode   = MODE_ADD;
      dec_ref    = lr_rank;
      dec_kvs_we = 1'b1;
      dec_clr    = do_evict;
      dec_clr_idx = lr_idx;
      dec_set    = 1'b1;
      dec_sweep  = 1'b1;
      if (do_evict) begin
        dec_target = (free_found && (free_idx < lr_idx)) ? free_idx : lr_idx;
        dec_occ    = occ;
      end else begin
        dec_target = free_found ? free_idx : '0;
        dec_occ    = occ + OCC_W'(1);
      end
    end
  end

  // Store strobes, addresses and rank update unit
  always_comb begin
    mem_ctl.kvs_we    = (state == S_DECIDE) && dec_kvs_we;
    mem_ctl.valid_clr = (state == S_DECIDE) && dec_clr;
    mem_ctl.valid_set = (state == S_DECIDE) && dec_set;
    mem_ctl.rank_we   = sweep_proc && rd_valid;
    raddr     = idx;
    kvs_addr  = dec_target;
    wkey      = key_q;
    wvalue    = value_q;
    wstamp    = tick_count;
    clr_idx   = dec_clr_idx;
    set_idx   = dec_target;
    rank_addr = rd_idx;
    if (rd_idx == target_idx) begin
      wrank = '0;
    end else begin
      unique case (mode)
        MODE_TOUCH:  wrank = (rd_rank < ref_rank) ? rd_rank + IDX_W'(1) : rd_rank;
        MODE_REMOVE: wrank = (rd_rank > ref_rank) ? rd_rank - IDX_W'(1) : rd_rank;
        MODE_ADD: begin
          wrank = (evict && (rd_rank > ref_rank)) ? rd_rank : rd_rank + IDX_W'(1);
        end
        default:     wrank = rd_rank;
      endcase
    end
    res.valid  = (state == S_FINISH);
    res.status = status_q;
    res_handle = handle_q;
  end

  // Walk counter and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (issue && !idx_last) begin
        idx <= idx + IDX_W'(1);
      end else begin
        idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;
  end

  // Capture request, collect scan results
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      key_q      <= key;
      value_q    <= value;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      lr_found   <= 1'b0;
    end else if (scan_proc) begin
      if (rd_valid && (rd_key == key_q) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_rank  <= rd_rank;
        hit_value <= rd_value;
        hit_stamp <= rd_stamp;
      end
      if (!rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if (rd_valid && (!lr_found || (rd_rank > lr_rank))) begin
        lr_found <= 1'b1;
        lr_idx   <= rd_idx;
        lr_rank  <= rd_rank;
        lr_value <= rd_value;
      end
    end
  end

  // Latch decision for the sweep and the result
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= RES_TICK;
      handle_q <= '0;
    end else if (state == S_DECIDE) begin
      status_q   <= dec_status;
      handle_q   <= dec_handle;
      mode       <= dec_mode;
      ref_rank   <= dec_ref;
      target_idx <= dec_target;
      evict      <= dec_clr && (op_q == OP_INSERT);
    end
  end

  // Occupancy and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      tick_count <= '0;
    end else begin
      if (state == S_DECIDE) begin
        occ <= dec_occ;
      end
      if (accept && (op == OP_TICK)) begin
        tick_count <= tick_count + STAMP_W'(1);
      end
    end
  end

endmodule

### rtl/lru_cache_with_ttl_expiry_top.sv
// ----------------------------------------------------------------------------
// A hit, expiry or insert walks the entry memories twice, a scan and a rank
// sweep; a lookup miss walks them once; a tick does not walk them at all.
// One request at a time: the next is taken only after the result has been
// passed to the output register, which an output stall can hold off.
// Each walk reads the entry memories one entry a cycle. Reset clears valid
// flags, occupancy, tick count and registers.
// ----------------------------------------------------------------------------
// lru_cache_with_ttl_expiry_top
// Fully associative cache table with LRU replacement and TTL expiry:
// configuration registers, sequencer, entry store and output register.
// ----------------------------------------------------------------------------
module lru_cache_with_ttl_expiry_top import lct_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        op,
  input  logic [KEY_BITS-1:0]    key,
  input  logic [VALUE_BITS-1:0]  value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [VALUE_BITS-1:0]  handle,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic [CAP_W-1:0]      capacity;
  logic [TTL_W-1:0]      ttl;
  logic                  busy;
  lct_mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W-1:0]      kvs_addr;
  logic [KEY_BITS-1:0]   wkey;
  logic [VALUE_BITS-1:0] wvalue;
  logic [STAMP_W-1:0]    wstamp;
  logic [IDX_W-1:0]      rank_addr;
  logic [IDX_W-1:0]      wrank;
  logic [IDX_W-1:0]      clr_idx;
  logic [IDX_W-1:0]      set_idx;
  logic                  rd_valid;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  logic [STAMP_W-1:0]    rd_stamp;
  logic [IDX_W-1:0]      rd_rank;
  lct_res_t              res;
  logic [VALUE_BITS-1:0] res_handle;
  logic                  res_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      ttl      <= TTL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        CFG_TTL:      ttl      <= cfg_data[TTL_W-1:0];
        default:      ;
      endcase
    end
  end

  assign in_stall = busy;

  lct_seq #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .busy      (busy),
    .op        (op),
    .key       (key),
    .value     (value),
    .capacity  (capacity),
    .ttl       (ttl),
    .mem_ctl   (mem_ctl),
    .raddr     (raddr),
    .kvs_addr  (kvs_addr),
    .wkey      (wkey),
    .wvalue    (wvalue),
    .wstamp    (wstamp),
    .rank_addr (rank_addr),
    .wrank     (wrank),
    .clr_idx   (clr_idx),
    .set_idx   (set_idx),
    .rd_valid  (rd_valid),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .rd_stamp  (rd_stamp),
    .rd_rank   (rd_rank),
    .res       (res),
    .res_handle(res_handle),
    .res_ready (res_ready)
  );

  lct_store #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .raddr    (raddr),
    .kvs_addr (kvs_addr),
    .wkey     (wkey),
    .wvalue   (wvalue),
    .wstamp   (wstamp),
    .rank_addr(rank_addr),
    .wrank    (wrank),
    .clr_idx  (clr_idx),
    .set_idx  (set_idx),
    .rd_valid (rd_valid),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .rd_stamp (rd_stamp),
    .rd_rank  (rd_rank)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      status <= res.status;
      handle <= res_handle;
    end
  end

endmodule

### rtl/lct_checker.sv
// ----------------------------------------------------------------------------
// lct_checker
// Port-level checks on the cache table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lct_checker import lct_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [OP_W-1:0]       op,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATUS_W-1:0]   status,
  input logic [VALUE_BITS-1:0] handle
);

  // Reset leaves the block idle with nothing to deliver
  `LCT_ASSERT_NEXT_NORST(a_reset_idle, clk, rst, !out_valid && !in_stall)

  // A held result does not change
  `LCT_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(handle))

  // Any real request keeps the block busy in the next cycle
  `LCT_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && !in_stall && (op == OP_LOOKUP || op == OP_INSERT || op == OP_TICK), in_stall)

  // Miss, plain insert and tick carry no handle
  `LCT_ASSERT_IMPLY(a_empty_handle, clk, rst, out_valid && (status == RES_MISS || status == RES_INSERTED || status == RES_TICK), handle == '0)

endmodule

bind lru_cache_with_ttl_expiry_top lct_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_lct_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .op       (op),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .handle   (handle)
);
